// ----- sv/exptok_pkg.sv -----
// Shared types and constants of the expression tokenizer.
package exptok_pkg;

   localparam int MAX_LEN     = 4096;
   localparam int POS_W       = $clog2(MAX_LEN + 1);
   localparam int START_W     = 12;
   localparam int LEN_W       = 13;
   localparam int FIDX_W      = 3;
   localparam int MAX_TOKENS  = 3;
   localparam int CNT_W       = $clog2(MAX_TOKENS + 1);
   localparam int TIDX_W      = $clog2(MAX_TOKENS);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      TK_NUM    = 4'd0,
      TK_VAR    = 4'd1,
      TK_FUNC   = 4'd2,
      TK_PLUS   = 4'd3,
      TK_MINUS  = 4'd4,
      TK_STAR   = 4'd5,
      TK_SLASH  = 4'd6,
      TK_CARET  = 4'd7,
      TK_LPAREN = 4'd8,
      TK_RPAREN = 4'd9,
      TK_COMMA  = 4'd10,
      TK_END    = 4'd11,
      TK_BAD    = 4'd12,
      TK_LONG   = 4'd13
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type         kind;
      logic [START_W-1:0]   start;
      logic [LEN_W-1:0]     len;
      logic [FIDX_W-1:0]    fidx;
      logic                 frac;
      logic                 last;
   } token_type;

   // All tokens caused by one request, oldest in slot 0.
   typedef struct packed {
      token_type [MAX_TOKENS-1:0] toks;
      logic [CNT_W-1:0]           count;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic idle;
      logic dropping;
   } scan_status_type;

endpackage

// ----- sv/expression_tokenizer.sv -----
// Top level of the streaming arithmetic expression tokenizer.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_push / req_full | req_kind, req_char_byte
//   rsp     | out       | rsp_pop / rsp_empty | token_kind, start_pos, token_length,
//           |           |                     | func_index, fraction, last
//
// Cycles: a request is taken whenever the bundle queue has room, so characters
//   stream in at one per cycle until it fills. Tokens leave one per cycle from
//   the output register while rsp_pop is held; a request yields up to three
//   tokens, so the output drain rate and the four-entry bundle queue set the rate.
// Reset: synchronous, active high; scanner idle, queue and output empty.
// Stalls: req_full rises only when the bundle queue is full; a stalled rsp
//   side backs up into the queue without disturbing the scanner state.
module expression_tokenizer
   import exptok_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic                req_kind,
   input  logic [7:0]          req_char_byte,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [3:0]          rsp_token_kind,
   output logic [START_W-1:0]  rsp_start_pos,
   output logic [LEN_W-1:0]    rsp_token_length,
   output logic [FIDX_W-1:0]   rsp_func_index,
   output logic                rsp_fraction,
   output logic                rsp_last
);

   // scanner -> queue
   logic             wr_en;
   bundle_type       wr_data;
   scan_status_type  scan_stat;
   // queue -> output stage
   queue_status_type q_stat;
   bundle_type       q_data;
   logic             q_pop;
   token_type        rsp_tok;

   exptok_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_kind      (req_kind),
      .req_char_byte (req_char_byte),
      .q_full        (q_stat.full),
      .wr_en         (wr_en),
      .wr_data       (wr_data),
      .scan_stat     (scan_stat)
   );

   exptok_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_data (wr_data),
      .rd_en   (q_pop),
      .rd_data (q_data),
      .q_stat  (q_stat)
   );

   exptok_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_tok   (rsp_tok)
   );

   assign req_full         = q_stat.full;
   assign rsp_token_kind   = 4'(rsp_tok.kind);
   assign rsp_start_pos    = rsp_tok.start;
   assign rsp_token_length = rsp_tok.len;
   assign rsp_func_index   = rsp_tok.fidx;
   assign rsp_fraction     = rsp_tok.frac;
   assign rsp_last         = rsp_tok.last;

   // an accepted end request leaves the scanner idle and out of drop mode
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_kind) |=> (scan_stat.idle && !scan_stat.dropping))
      else $error("scanner not cleared after end request");

   // a bundle is only written when it holds at least one token and there is room
   a_wr_sane: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_data.count != '0 && !q_stat.full))
      else $error("bad bundle write");

   // reset leaves the result side empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result side not empty after reset");

endmodule

// ----- sv/exptok_scan.sv -----
// Front end: takes characters, tracks the scan state, builds token bundles.
module exptok_scan
   import exptok_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   input  logic            req_kind,
   input  logic [7:0]      req_char_byte,
   input  logic            q_full,
   output logic            wr_en,
   output bundle_type      wr_data,
   output scan_status_type scan_stat
);

   typedef enum logic [4:0] {
      MODE_IDLE  = 5'b00001,
      MODE_WORD  = 5'b00010,
      MODE_INT   = 5'b00100,
      MODE_SLASH = 5'b01000,
      MODE_DEN   = 5'b10000
   } scan_mode_type;

   localparam int FN_COUNT = 7;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;

   // sin cos tan cot sqrt exp log, lower case
   localparam logic [7:0] FN_CHR [FN_COUNT][4] = '{
      '{8'h73, 8'h69, 8'h6E, 8'h00},
      '{8'h63, 8'h6F, 8'h73, 8'h00},
      '{8'h74, 8'h61, 8'h6E, 8'h00},
      '{8'h63, 8'h6F, 8'h74, 8'h00},
      '{8'h73, 8'h71, 8'h72, 8'h74},
      '{8'h65, 8'h78, 8'h70, 8'h00},
      '{8'h6C, 8'h6F, 8'h67, 8'h00}
   };
   localparam logic [2:0] FN_LEN [FN_COUNT] = '{3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3};

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
   endfunction

   function automatic logic [START_W-1:0] sat_pos(input logic [POS_W-1:0] p);
      return (32'(p) > 32'((1 << START_W) - 1)) ? {START_W{1'b1}} : START_W'(p);
   endfunction

   function automatic logic [FN_COUNT-1:0] match_letter(input logic [FN_COUNT-1:0] mask,
                                                        input logic [2:0] k,
                                                        input logic [7:0] c);
      logic [FN_COUNT-1:0] m;
      logic [7:0]          lower;
      m     = mask;
      lower = c | 8'h20;
      for (int f = 0; f < FN_COUNT; f++) begin
         if (!((k < FN_LEN[f]) && (FN_CHR[f][k[1:0]] == lower))) m[f] = 1'b0;
      end
      return m;
   endfunction

   function automatic token_type mk_tok(input tok_kind_type k, input logic [START_W-1:0] s,
                                        input logic [LEN_W-1:0] l, input logic [FIDX_W-1:0] fi,
                                        input logic fr, input logic la);
      token_type t;
      t.kind  = k;
      t.start = s;
      t.len   = l;
      t.fidx  = fi;
      t.frac  = fr;
      t.last  = la;
      return t;
   endfunction

   scan_mode_type       mode_ff, mode_in;
   logic [POS_W-1:0]    tstart_ff, tstart_in;
   logic [POS_W-1:0]    cpos_ff, cpos_in;
   logic [FN_COUNT-1:0] mask_ff, mask_in;
   logic [2:0]          wlen_ff, wlen_in;
   logic                frac_ff, frac_in;
   logic                drop_ff, drop_in;

   logic                accept;
   logic [POS_W-1:0]    pos;
   logic [POS_W-1:0]    pos_m1;
   logic                fn_hit;
   logic [FIDX_W-1:0]   fn_idx;
   token_type [1:0]     fl_tok;
   logic [1:0]          fl_cnt;
   bundle_type          bnd;
   logic                cont;
   tok_kind_type        op_kind;
   logic                op_ok;

   assign accept = req_push & ~q_full;
   assign pos    = cpos_ff;
   assign pos_m1 = cpos_ff - POS_W'(1);

   // function name lookup over the surviving candidates, lowest index wins
   always_comb begin
      fn_hit = 1'b0;
      fn_idx = '0;
      for (int f = FN_COUNT - 1; f >= 0; f--) begin
         if (mask_ff[f] && (FN_LEN[f] == wlen_ff)) begin
            fn_hit = 1'b1;
            fn_idx = FIDX_W'(f);
         end
      end
   end

   // token in progress, closed at the current position
   always_comb begin
      fl_tok = '0;
      fl_cnt = 2'd0;
      case (mode_ff)
         MODE_WORD: begin
            fl_tok[0] = mk_tok(fn_hit ? TK_FUNC : TK_VAR, START_W'(tstart_ff),
                               LEN_W'(pos - tstart_ff), fn_idx, 1'b0, 1'b0);
            fl_cnt    = 2'd1;
         end
         MODE_INT, MODE_DEN: begin
            fl_tok[0] = mk_tok(TK_NUM, START_W'(tstart_ff), LEN_W'(pos - tstart_ff),
                               '0, frac_ff, 1'b0);
            fl_cnt    = 2'd1;
         end
         MODE_SLASH: begin
            fl_tok[0] = mk_tok(TK_NUM, START_W'(tstart_ff), LEN_W'(pos_m1 - tstart_ff),
                               '0, 1'b0, 1'b0);
            fl_tok[1] = mk_tok(TK_SLASH, START_W'(pos_m1), LEN_W'(1), '0, 1'b0, 1'b0);
            fl_cnt    = 2'd2;
         end
         default: begin
            fl_cnt = 2'd0;
         end
      endcase
   end

   always_comb begin
      op_ok   = 1'b1;
      op_kind = TK_PLUS;
      case (req_char_byte)
         CH_PLUS:   op_kind = TK_PLUS;
         CH_MINUS:  op_kind = TK_MINUS;
         CH_STAR:   op_kind = TK_STAR;
         CH_SLASH:  op_kind = TK_SLASH;
         CH_CARET:  op_kind = TK_CARET;
         CH_LPAREN: op_kind = TK_LPAREN;
         CH_RPAREN: op_kind = TK_RPAREN;
         CH_COMMA:  op_kind = TK_COMMA;
         default:   op_ok   = 1'b0;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      tstart_in = tstart_ff;
      cpos_in   = cpos_ff;
      mask_in   = mask_ff;
      wlen_in   = wlen_ff;
      frac_in   = frac_ff;
      drop_in   = drop_ff;
      bnd       = '0;
      cont      = 1'b0;
      if (req_kind) begin
         if (!drop_ff) begin
            for (int i = 0; i < 2; i++) begin
               if (2'(i) < fl_cnt) begin
                  bnd.toks[bnd.count[TIDX_W-1:0]] = fl_tok[i];
                  bnd.count = bnd.count + CNT_W'(1);
               end
            end
            bnd.toks[bnd.count[TIDX_W-1:0]] = mk_tok(TK_END, sat_pos(pos), '0, '0, 1'b0, 1'b1);
            bnd.count = bnd.count + CNT_W'(1);
         end
         mode_in   = MODE_IDLE;
         tstart_in = '0;
         cpos_in   = '0;
         mask_in   = '0;
         wlen_in   = '0;
         frac_in   = 1'b0;
         drop_in   = 1'b0;
      end else if (!drop_ff) begin
         if (pos >= POS_W'(MAX_LEN)) begin
            bnd.toks[0] = mk_tok(TK_LONG, sat_pos(pos), '0, '0, 1'b0, 1'b1);
            bnd.count   = CNT_W'(1);
            mode_in     = MODE_IDLE;
            drop_in     = 1'b1;
         end else begin
            cpos_in = pos + POS_W'(1);
            case (mode_ff)
               MODE_WORD: begin
                  if (is_letter(req_char_byte)) begin
                     cont    = 1'b1;
                     mask_in = match_letter(mask_ff, wlen_ff, req_char_byte);
                     if (wlen_ff != 3'd7) wlen_in = wlen_ff + 3'd1;
                  end
               end
               MODE_INT: begin
                  if (is_digit(req_char_byte)) begin
                     cont = 1'b1;
                  end else if (req_char_byte == CH_SLASH) begin
                     cont    = 1'b1;
                     mode_in = MODE_SLASH;
                  end
               end
               MODE_SLASH: begin
                  if (is_digit(req_char_byte)) begin
                     cont    = 1'b1;
                     mode_in = MODE_DEN;
                     frac_in = 1'b1;
                  end
               end
               MODE_DEN: begin
                  if (is_digit(req_char_byte)) cont = 1'b1;
               end
               default: begin
                  cont = 1'b0;
               end
            endcase
            if (!cont) begin
               for (int i = 0; i < 2; i++) begin
                  if (2'(i) < fl_cnt) begin
                     bnd.toks[bnd.count[TIDX_W-1:0]] = fl_tok[i];
                     bnd.count = bnd.count + CNT_W'(1);
                  end
               end
               mode_in = MODE_IDLE;
               if (is_space(req_char_byte)) begin
                  mode_in = MODE_IDLE;
               end else if (is_letter(req_char_byte)) begin
                  mode_in   = MODE_WORD;
                  tstart_in = pos;
                  mask_in   = match_letter({FN_COUNT{1'b1}}, 3'd0, req_char_byte);
                  wlen_in   = 3'd1;
               end else if (is_digit(req_char_byte)) begin
                  mode_in   = MODE_INT;
                  tstart_in = pos;
                  frac_in   = 1'b0;
               end else begin
                  bnd.toks[bnd.count[TIDX_W-1:0]] =
                     mk_tok(op_ok ? op_kind : TK_BAD, START_W'(pos), LEN_W'(1), '0, 1'b0, ~op_ok);
                  bnd.count = bnd.count + CNT_W'(1);
                  if (!op_ok) drop_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         tstart_ff <= '0;
         cpos_ff   <= '0;
         mask_ff   <= '0;
         wlen_ff   <= '0;
         frac_ff   <= 1'b0;
         drop_ff   <= 1'b0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         tstart_ff <= tstart_in;
         cpos_ff   <= cpos_in;
         mask_ff   <= mask_in;
         wlen_ff   <= wlen_in;
         frac_ff   <= frac_in;
         drop_ff   <= drop_in;
      end
   end

   assign wr_en              = accept & (bnd.count != '0);
   assign wr_data            = bnd;
   assign scan_stat.idle     = (mode_ff == MODE_IDLE);
   assign scan_stat.dropping = drop_ff;

endmodule

// ----- sv/exptok_queue.sv -----
// Short queue of token bundles between the scanner and the output stage.
module exptok_queue
   import exptok_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  bundle_type       wr_data,
   input  logic             rd_en,
   output bundle_type       rd_data,
   output queue_status_type q_stat
);

   bundle_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_wr;
   logic              do_rd;

   assign do_wr = wr_en & ~q_stat.full;
   assign do_rd = rd_en & ~q_stat.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_wr && !do_rd) cnt_in = cnt_ff + QCNT_W'(1);
      else if (do_rd && !do_wr) cnt_in = cnt_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

   assign rd_data      = mem_ff[rd_ptr_ff];
   assign q_stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);

endmodule

// ----- sv/exptok_unpack.sv -----
// Back end: holds one bundle and hands out its tokens one per pop.
module exptok_unpack
   import exptok_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_stat,
   input  bundle_type       q_data,
   output logic             q_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output token_type        rsp_tok
);

   bundle_type        cur_ff, cur_in;
   logic [TIDX_W-1:0] idx_ff, idx_in;
   logic              vld_ff, vld_in;
   logic              take;
   logic              done;

   assign take  = vld_ff & rsp_pop;
   assign done  = take & (CNT_W'(idx_ff) == cur_ff.count - CNT_W'(1));
   assign q_pop = ~q_stat.empty & (~vld_ff | done);

   always_comb begin
      cur_in = cur_ff;
      idx_in = idx_ff;
      vld_in = vld_ff;
      if (q_pop) begin
         cur_in = q_data;
         idx_in = '0;
         vld_in = 1'b1;
      end else if (done) begin
         vld_in = 1'b0;
      end else if (take) begin
         idx_in = idx_ff + TIDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_empty = ~vld_ff;
   assign rsp_tok   = cur_ff.toks[idx_ff];

endmodule

// ----- verif/tb_expression_tokenizer.sv -----
// Self-checking testbench for the streaming expression tokenizer.
`timescale 1ns / 100ps

module tb_expression_tokenizer;
   import exptok_pkg::*;

   // No request or token moving for this many cycles means the run is stuck.
   // The longest legal quiet stretch is an idle burst on either side plus the
   // pipeline latency, so this is far beyond any correct run.
   localparam int WATCHDOG_LIMIT = 2000;
   // Settling time after the last expected token, to catch stray extra tokens.
   localparam int DRAIN_CYCLES   = 32;
   // Expression characters in the random part.
   localparam int RANDOM_CHARS   = 60;

   // Scanner modes of the predictor.
   typedef enum int {
      SCAN_IDLE,
      SCAN_WORD,
      SCAN_INT,
      SCAN_SLASH,
      SCAN_DEN
   } scan_mode_type;

   // Expected-token store plus its own copy of the scanner state. note_request()
   // runs the scan for each accepted request and queues the tokens it causes;
   // check_token() compares each popped token against the oldest one queued.
   class token_checker;
      token_type     expected_tokens[$];
      int unsigned   errors;
      int unsigned   checked;
      int unsigned   kind_hits[14];
      scan_mode_type mode;
      int unsigned   tok_start;
      int unsigned   char_pos;
      int unsigned   word_len;
      bit [6:0]      name_mask;
      bit            frac_seen;
      bit            dropping;
      string         fn_name[7];

      function new();
         fn_name = '{"sin", "cos", "tan", "cot", "sqrt", "exp", "log"};
         clear_expr();
      endfunction

      function void clear_expr();
         mode      = SCAN_IDLE;
         tok_start = 0;
         char_pos  = 0;
         name_mask = '0;
         word_len  = 0;
         frac_seen = 1'b0;
         dropping  = 1'b0;
      endfunction

      function int unsigned sat_pos(int unsigned p);
         return (p > 4095) ? 4095 : p;
      endfunction

      function void emit(tok_kind_type k, int unsigned start, int unsigned len,
                         int unsigned fidx, bit frac, bit last);
         token_type t;
         t.kind  = k;
         t.start = start[START_W-1:0];
         t.len   = len[LEN_W-1:0];
         t.fidx  = fidx[FIDX_W-1:0];
         t.frac  = frac;
         t.last  = last;
         expected_tokens = {expected_tokens, t};
      endfunction

      // Narrow the set of function names still matching the word so far.
      function void add_letter(logic [7:0] c);
         logic [7:0] lower;
         lower = c | 8'h20;
         for (int f = 0; f < 7; f++) begin
            if (word_len >= fn_name[f].len() || fn_name[f][word_len] != lower)
               name_mask[f] = 1'b0;
         end
         if (word_len < 7) word_len++;
      endfunction

      function void flush_word(int unsigned end_pos);
         for (int f = 0; f < 7; f++) begin
            if (name_mask[f] && fn_name[f].len() == word_len) begin
               emit(TK_FUNC, tok_start, end_pos - tok_start, f, 1'b0, 1'b0);
               return;
            end
         end
         emit(TK_VAR, tok_start, end_pos - tok_start, 0, 1'b0, 1'b0);
      endfunction

      // Close whatever token is open, ending at end_pos. A held slash after
      // digits turns into the number followed by a lone slash token.
      function void flush_pending(int unsigned end_pos);
         case (mode)
            SCAN_WORD: flush_word(end_pos);
            SCAN_INT, SCAN_DEN: begin
               emit(TK_NUM, tok_start, end_pos - tok_start, 0, frac_seen, 1'b0);
            end
            SCAN_SLASH: begin
               emit(TK_NUM, tok_start, end_pos - 1 - tok_start, 0, 1'b0, 1'b0);
               emit(TK_SLASH, end_pos - 1, 1, 0, 1'b0, 1'b0);
            end
            default: ;
         endcase
         mode = SCAN_IDLE;
      endfunction

      function void note_request(logic k, logic [7:0] c);
         int unsigned  pos;
         tok_kind_type op;
         bit           is_letter;
         bit           is_digit;
         bit           is_space;
         pos       = char_pos;
         is_letter = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
         is_digit  = (c >= "0" && c <= "9");
         is_space  = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);

         // End of expression: close the open token, then END. After an error
         // the end is silent and only rearms the scanner.
         if (k) begin
            if (!dropping) begin
               flush_pending(pos);
               emit(TK_END, sat_pos(pos), 0, 0, 1'b0, 1'b1);
            end
            clear_expr();
            return;
         end
         if (dropping) return;

         // Over-length expression: one error, open token thrown away.
         if (pos >= MAX_LEN) begin
            emit(TK_LONG, sat_pos(pos), 0, 0, 1'b0, 1'b1);
            mode     = SCAN_IDLE;
            dropping = 1'b1;
            return;
         end
         char_pos = pos + 1;

         // Characters that extend the open token.
         case (mode)
            SCAN_WORD: if (is_letter) begin
               add_letter(c);
               return;
            end
            SCAN_INT: begin
               if (is_digit) return;
               if (c == "/") begin
                  mode = SCAN_SLASH;
                  return;
               end
            end
            SCAN_SLASH: if (is_digit) begin
               mode      = SCAN_DEN;
               frac_seen = 1'b1;
               return;
            end
            SCAN_DEN: if (is_digit) return;
            default: ;
         endcase
         flush_pending(pos);

         if (is_space) return;
         if (is_letter) begin
            mode      = SCAN_WORD;
            tok_start = pos;
            name_mask = '1;
            word_len  = 0;
            add_letter(c);
            return;
         end
         if (is_digit) begin
            mode      = SCAN_INT;
            tok_start = pos;
            frac_seen = 1'b0;
            return;
         end
         case (c)
            "+": op = TK_PLUS;
            "-": op = TK_MINUS;
            "*": op = TK_STAR;
            "/": op = TK_SLASH;
            "^": op = TK_CARET;
            "(": op = TK_LPAREN;
            ")": op = TK_RPAREN;
            ",": op = TK_COMMA;
            default: begin
               emit(TK_BAD, pos, 1, 0, 1'b0, 1'b1);
               dropping = 1'b1;
               return;
            end
         endcase
         emit(op, pos, 1, 0, 1'b0, 1'b0);
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 10) $display("MISMATCH @%0t: %s", $realtime, msg);
      endfunction

      function void check_token(logic [3:0] kind, logic [START_W-1:0] start,
                                logic [LEN_W-1:0] len, logic [FIDX_W-1:0] fidx,
                                logic frac, logic last);
         token_type e;
         checked++;
         if (!$isunknown(kind) && kind < 14) kind_hits[kind]++;
         if (expected_tokens.size() == 0) begin
            report($sformatf("unexpected token kind %0d start %0d len %0d",
                             kind, start, len));
            return;
         end
         e = expected_tokens.pop_front();
         if (kind !== e.kind || start !== e.start || len !== e.len ||
             fidx !== e.fidx || frac !== e.frac || last !== e.last)
            report($sformatf({"token %0d: expected kind %0d start %0d len %0d ",
                              "func %0d frac %0d last %0d, got %0d %0d %0d %0d %0d %0d"},
                             checked, e.kind, e.start, e.len, e.fidx, e.frac, e.last,
                             kind, start, len, fidx, frac, last));
      endfunction
   endclass

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_push      = 1'b0;
   logic                req_full;
   logic                req_kind      = 1'b0;
   logic [7:0]          req_char_byte = 8'h00;
   logic                rsp_empty;
   logic                rsp_pop       = 1'b0;
   logic [3:0]          rsp_token_kind;
   logic [START_W-1:0]  rsp_start_pos;
   logic [LEN_W-1:0]    rsp_token_length;
   logic [FIDX_W-1:0]   rsp_func_index;
   logic                rsp_fraction;
   logic                rsp_last;

   token_checker sb = new();

   // Idle bursts are switched off for the tail of the run.
   bit          send_idling = 1'b1;
   bit          recv_idling = 1'b1;
   int unsigned chars_sent;
   int unsigned exprs_sent;
   int unsigned quiet_cycles;
   int unsigned pop_stall;

   // Words that hit, almost hit, or overrun the function names.
   string name_pool[14] = '{"sin", "cos", "tan", "cot", "sqrt", "exp", "log",
                            "si", "sqr", "sine", "logs", "x", "ab", "alphabet"};
   string op_chars      = "+-*/^(),";

   expression_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_char_byte    (req_char_byte),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_start_pos    (rsp_start_pos),
      .rsp_token_length (rsp_token_length),
      .rsp_func_index   (rsp_func_index),
      .rsp_fraction     (rsp_fraction),
      .rsp_last         (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Token side: sample at the edge, then pick pop for the next cycle. Stalls
   // come in random-length bursts; only one pop assignment per edge.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty)
            sb.check_token(rsp_token_kind, rsp_start_pos, rsp_token_length,
                           rsp_func_index, rsp_fraction, rsp_last);
         if (pop_stall > 0) begin
            pop_stall--;
            rsp_pop <= 1'b0;
         end else if (recv_idling && $urandom_range(0, 7) == 0) begin
            pop_stall = $urandom_range(1, 9) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog: counts cycles in which neither a request nor a token moves.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TIMEOUT: no request or token moved for %0d cycles, %0d tokens pending",
                     quiet_cycles, sb.expected_tokens.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   // One request; an optional idle burst first. Returns at the accepting edge.
   task automatic push_request(input logic k, input logic [7:0] c);
      if (send_idling && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_kind      <= k;
      req_char_byte <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      sb.note_request(k, c);
      if (k) exprs_sent++;
      else chars_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) push_request(1'b0, s[i]);
   endtask

   // The character byte is don't-care on an end request; keep it random.
   task automatic send_end();
      push_request(1'b1, 8'($urandom_range(0, 255)));
   endtask

   function automatic bit is_token_char(logic [7:0] c);
      bit hit;
      hit = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
            (c >= "0" && c <= "9") || c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
      for (int i = 0; i < op_chars.len(); i++)
         if (c == op_chars[i]) hit = 1'b1;
      return hit;
   endfunction

   task automatic send_digits(input int n);
      repeat (n) push_request(1'b0, 8'h30 + 8'($urandom_range(0, 9)));
   endtask

   // Mostly well-formed expressions with random content: names (random case),
   // integers, fractions, dangling slashes, operators and whitespace, with
   // some bad characters and raw noise mixed in. Always closed by an end.
   task automatic send_random_expr();
      int         pieces;
      int         choice;
      string      w;
      logic [7:0] c;
      pieces = $urandom_range(0, 6);
      repeat (pieces) begin
         choice = $urandom_range(0, 99);
         if (choice < 25) begin
            w = name_pool[$urandom_range(0, 13)];
            for (int i = 0; i < w.len(); i++) begin
               c = w[i];
               if ($urandom_range(0, 1)) c[5] = 1'b0;
               push_request(1'b0, c);
            end
         end else if (choice < 45) begin
            send_digits($urandom_range(1, 4));
            choice = $urandom_range(0, 99);
            if (choice < 40) begin
               push_request(1'b0, "/");
               send_digits($urandom_range(1, 3));
            end else if (choice < 55) begin
               push_request(1'b0, "/");
            end
         end else if (choice < 70) begin
            push_request(1'b0, op_chars[$urandom_range(0, 7)]);
         end else if (choice < 85) begin
            repeat ($urandom_range(1, 3)) begin
               c = 8'($urandom_range(8, 13));
               push_request(1'b0, (c == 8'd8) ? 8'd32 : c);
            end
         end else if (choice < 90) begin
            do c = 8'($urandom_range(0, 255)); while (is_token_char(c));
            push_request(1'b0, c);
         end else begin
            push_request(1'b0, 8'($urandom_range(0, 255)));
         end
      end
      send_end();
   endtask

   initial begin
      int kinds_seen;
      int unsigned random_start;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      // Function name in mixed case, parentheses and a fraction.
      send_text("Cos(12/5)");
      send_end();
      // Slash after digits not followed by a digit, vertical tab as separator,
      // and a dangling slash at the end (three tokens from the end request).
      send_text("4/x");
      push_request(1'b0, 8'd11);
      send_text("7/");
      send_end();
      // Remaining operators and whitespace, then a NUL as a bad character:
      // the open word is flushed first and the rest of the line is dropped.
      send_text("-*,^+");
      push_request(1'b0, 8'd12);
      push_request(1'b0, 8'd13);
      send_text("x");
      push_request(1'b0, 8'h00);
      send_text("y");
      send_end();
      // Top byte value as a bad character, then an empty expression.
      push_request(1'b0, 8'hFF);
      send_end();
      send_end();

      // Random part; the last quarter runs without idle bursts.
      random_start = chars_sent;
      while (chars_sent - random_start < RANDOM_CHARS) begin
         if (chars_sent - random_start >= RANDOM_CHARS * 3 / 4) begin
            send_idling = 1'b0;
            recv_idling = 1'b0;
         end
         send_random_expr();
      end
      req_push <= 1'b0;

      while (sb.expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      kinds_seen = 0;
      for (int k = 0; k < 14; k++)
         if (sb.kind_hits[k] != 0) kinds_seen++;
      $display("Run covered %0d characters in %0d expressions, directed and random.",
               chars_sent, exprs_sent);
      $display("%0d tokens checked, %0d of 14 token kinds seen, %0d mismatches.",
               sb.checked, kinds_seen, sb.errors);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/exptok_pkg.sv
sv/exptok_scan.sv
sv/exptok_queue.sv
sv/exptok_unpack.sv
sv/expression_tokenizer.sv
verif/tb_expression_tokenizer.sv
